FILE: rtl/core/bbd_pkg.sv
// Shared types, constants and fixed-point helpers for the B-spline basis
// derivative block. Used by the divider and the top level; no dependencies.
package bbd_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MAX_DEGREE_DEF = 3;
  localparam int MAX_KNOTS_DEF  = 16;

  // Q16.16 constants.
  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = -32'sh8000_0000;

  // Span search gives up after this many halvings.
  localparam int SEARCH_STEPS = 8;

  // Divider: 48 quotient bits, two per cycle.
  localparam int DIV_BITS      = 48;
  localparam int DIV_PER_CYCLE = 2;
  localparam int DIV_CYCLES    = DIV_BITS / DIV_PER_CYCLE;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES + 1);

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_DEGREE = 2'd0;
  localparam logic [1:0] REG_DERIV  = 2'd1;
  localparam logic [1:0] REG_BASIS  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [1:0] DEGREE_RST = 2'd2;
  localparam logic [1:0] DERIV_RST  = 2'd2;
  localparam logic [3:0] BASIS_RST  = 4'd5;

  // Input word actions.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [3:0]         knot_index;
    logic signed [31:0] knot_value;
    logic signed [31:0] point;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         deriv_order;
    logic [3:0]         basis_index;
    logic [3:0]         span_index;
    logic signed [31:0] value;
    logic               divide_flag;
    logic               last;
  } out_word_t;

  // Status returned by the divider.
  typedef struct packed {
    logic               done;
    logic               zero;
    logic signed [31:0] quot;
  } div_res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH_N,
    ST_SRCH_P,
    ST_SRCH_PCHK,
    ST_MID_A,
    ST_MID_B,
    ST_MID_C,
    ST_BUILD_INIT,
    ST_LR_A,
    ST_LR_B,
    ST_LR_C,
    ST_R_A,
    ST_R_DIV,
    ST_R_M1,
    ST_R_M2,
    ST_R_M3,
    ST_COPY,
    ST_DV_R,
    ST_DV_INIT,
    ST_T_A,
    ST_T_B,
    ST_T_DIV,
    ST_T_M,
    ST_T_ACC,
    ST_EMIT
  } bbd_state_t;

  // Clamp a wide signed value into 32 bits.
  function automatic logic signed [31:0] sat_wide(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = Q_MAX;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = Q_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Saturating add.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] res;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      res = s[32] ? Q_MIN : Q_MAX;
    end else begin
      res = s[31:0];
    end
    return res;
  endfunction

  // Saturating subtract.
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] res;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) begin
      res = s[32] ? Q_MIN : Q_MAX;
    end else begin
      res = s[31:0];
    end
    return res;
  endfunction

  // Rescale a raw product to Q16.16, truncating toward zero.
  function automatic logic signed [31:0] qmul_fix(input logic signed [63:0] prod);
    logic signed [63:0] t;
    t = prod[63] ? (prod + 64'sd65535) : prod;
    t = t >>> 16;
    return sat_wide(t);
  endfunction

endpackage

FILE: rtl/core/bspline_basis_derivatives.sv
// B-spline basis values and derivatives in Q16.16 with a knot store.
// A knot write word gives no result. An evaluate word runs the span search, then
// one quotient per table entry (p(p+1)/2 of them) plus one per derivative term from
// the shared two-bit-per-cycle divider, then one result word per cycle while the
// output is not stalled. One word at a time.
// Reset sets degree 2, order 2 and 5 basis functions; the knot store is not cleared.
module bspline_basis_derivatives #(
  parameter int MAX_DEGREE = bbd_pkg::MAX_DEGREE_DEF,
  parameter int MAX_KNOTS  = bbd_pkg::MAX_KNOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input words.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bbd_pkg::in_word_t             in_item,
  // Result words.
  output logic                          out_valid,
  input  logic                          out_stall,
  output bbd_pkg::out_word_t            out_item,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bbd_pkg::*;

  localparam int ND = MAX_DEGREE + 1;
  localparam int CW = $clog2(MAX_DEGREE + 2);
  localparam int IW = $clog2(MAX_DEGREE + 1);
  localparam int AW = $clog2(MAX_KNOTS);

  bbd_state_t state, state_next;

  // Configuration registers and their effective values.
  logic [1:0]    degree;
  logic [1:0]    max_deriv_order;
  logic [3:0]    basis_count;
  logic [CW-1:0] p_eff;
  logic [CW-1:0] k_eff;
  logic [3:0]    n_eff;

  // Search state.
  logic signed [31:0] x;
  logic [3:0]         span;
  logic [3:0]         lo, hi, mid;
  logic [3:0]         lo2, hi2, mid2;
  logic [2:0]         step;
  logic signed [31:0] kmid;
  logic               hit;

  // Table build state.
  logic [CW-1:0]      j, r, i, c, cend;
  logic               s1;
  logic signed [31:0] saved, tmp, ta, tb, tq, d, dn;
  logic               flag;
  logic signed [63:0] prod;
  logic signed [31:0] qm;
  logic signed [31:0] ndu   [ND][ND];
  logic signed [31:0] lft   [ND];
  logic signed [31:0] rgt   [ND];
  logic signed [31:0] acoef [2][ND];
  logic signed [31:0] ders  [ND][ND];

  // Index arithmetic.
  logic [CW-1:0] r_p1, j_mr, j_m1, c_m1, pi_p1, rk_c, p_mi;

  // Output sequencing.
  logic [CW-1:0]      oi, oj;
  logic [7:0]         mult;
  logic               emit_last;
  logic               slot_free;
  logic signed [63:0] scaled;
  out_word_t          emit_word;

  // Shared resources.
  logic [5:0]         kidx;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        ram_rdata;
  logic signed [31:0] knot_rd;
  logic               ram_we;
  logic [CW-1:0]      nrow, ncol;
  logic signed [31:0] ndu_rd;
  logic signed [31:0] rsum;
  logic               div_start;
  logic signed [31:0] div_num, div_den;
  div_res_t           div_res;
  logic signed [31:0] mul_a, mul_b;

  // Effective degree, order and basis count.
  always_comb begin
    p_eff = (int'(degree) > MAX_DEGREE) ? CW'(MAX_DEGREE) : CW'(degree);
    k_eff = (CW'(max_deriv_order) > p_eff) ? p_eff : CW'(max_deriv_order);
    n_eff = (basis_count < 4'(p_eff) + 4'd1) ? 4'(p_eff) + 4'd1 : basis_count;
  end

  // Configuration access.
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_DEGREE: prdata = {30'd0, degree};
      REG_DERIV:  prdata = {30'd0, max_deriv_order};
      REG_BASIS:  prdata = {28'd0, basis_count};
      default:    prdata = 32'd0;
    endcase
  end

  // Knot store.
  assign ram_we = (state == ST_IDLE) && in_valid && (in_item.action == ACT_WRITE) &&
                  (int'(in_item.knot_index) < MAX_KNOTS);
  assign knot_rd = ram_rdata;

  bbd_ram #(
    .WIDTH(32),
    .DEPTH(MAX_KNOTS)
  ) u_knots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_item.knot_index)),
    .wdata (in_item.knot_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Knot index clamped to the store.
  always_comb begin
    if (7'(kidx) > 7'(MAX_KNOTS - 1)) begin
      ram_raddr = AW'(MAX_KNOTS - 1);
    end else begin
      ram_raddr = AW'(kidx);
    end
  end

  // Shared divider.
  bbd_qdiv u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  // Index helpers.
  always_comb begin
    r_p1  = r + 1'b1;
    j_mr  = j - r;
    j_m1  = j - 1'b1;
    c_m1  = c - 1'b1;
    pi_p1 = p_eff - i + 1'b1;
    rk_c  = r - i + c;
    p_mi  = p_eff - i;
  end

  assign ndu_rd = ndu[nrow[IW-1:0]][ncol[IW-1:0]];
  assign rsum   = sat_add(rgt[r_p1[IW-1:0]], lft[j_mr[IW-1:0]]);
  assign qm     = qmul_fix(prod);
  assign dn     = sat_add(d, qm);
  assign tb     = (c == '0) ? 32'sd0 : acoef[s1][c_m1[IW-1:0]];

  // One step of the span search.
  always_comb begin
    hit  = (x >= kmid) && (x < knot_rd);
    lo2  = (x < kmid) ? lo : mid;
    hi2  = (x < kmid) ? mid : hi;
    mid2 = 4'(({1'b0, lo2} + {1'b0, hi2}) >> 1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (in_valid && (in_item.action == ACT_EVAL)) state_next = ST_SRCH_N;
      ST_SRCH_N:     state_next = ST_SRCH_P;
      ST_SRCH_P:     state_next = (x >= knot_rd) ? ST_BUILD_INIT : ST_SRCH_PCHK;
      ST_SRCH_PCHK:  state_next = (x <= knot_rd) ? ST_BUILD_INIT : ST_MID_A;
      ST_MID_A:      state_next = ST_MID_B;
      ST_MID_B:      state_next = ST_MID_C;
      ST_MID_C: begin
        if (hit || (step == 3'(SEARCH_STEPS - 1))) state_next = ST_BUILD_INIT;
        else                                       state_next = ST_MID_A;
      end
      ST_BUILD_INIT: state_next = (p_eff == '0) ? ST_COPY : ST_LR_A;
      ST_LR_A:       state_next = ST_LR_B;
      ST_LR_B:       state_next = ST_LR_C;
      ST_LR_C:       state_next = ST_R_A;
      ST_R_A:        state_next = ST_R_DIV;
      ST_R_DIV:      if (div_res.done) state_next = ST_R_M1;
      ST_R_M1:       state_next = ST_R_M2;
      ST_R_M2:       state_next = ST_R_M3;
      ST_R_M3: begin
        if (r == j_m1) state_next = (j == p_eff) ? ST_COPY : ST_LR_A;
        else           state_next = ST_R_A;
      end
      ST_COPY: begin
        if (c == p_eff) state_next = (k_eff == '0) ? ST_EMIT : ST_DV_R;
      end
      ST_DV_R:       state_next = ST_DV_INIT;
      ST_DV_INIT:    state_next = ST_T_A;
      ST_T_A:        state_next = ST_T_B;
      ST_T_B:        state_next = ST_T_DIV;
      ST_T_DIV:      if (div_res.done) state_next = ST_T_M;
      ST_T_M:        state_next = ST_T_ACC;
      ST_T_ACC: begin
        if (c == cend) begin
          if (i == k_eff) state_next = (r == p_eff) ? ST_EMIT : ST_DV_R;
          else            state_next = ST_DV_INIT;
        end else begin
          state_next = ST_T_A;
        end
      end
      ST_EMIT:       if (slot_free && emit_last) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Per-state selection of memory addresses, table reads and unit operands.
  always_comb begin
    kidx      = '0;
    nrow      = '0;
    ncol      = '0;
    div_start = 1'b0;
    div_num   = ndu_rd;
    div_den   = rsum;
    mul_a     = tq;
    mul_b     = ndu_rd;
    unique case (state)
      ST_SRCH_N: kidx = 6'(n_eff);
      ST_SRCH_P: kidx = 6'(p_eff);
      ST_MID_A:  kidx = 6'(mid);
      ST_MID_B:  kidx = 6'(mid) + 6'd1;
      ST_LR_A:   kidx = 6'(span) + 6'd1 - 6'(j);
      ST_LR_B:   kidx = 6'(span) + 6'(j);
      ST_R_A: begin
        nrow      = r;
        ncol      = j_m1;
        div_start = 1'b1;
        div_num   = ndu_rd;
        div_den   = rsum;
      end
      ST_R_M1: begin
        mul_a = rgt[r_p1[IW-1:0]];
        mul_b = tmp;
      end
      ST_R_M2: begin
        mul_a = lft[j_mr[IW-1:0]];
        mul_b = tmp;
      end
      ST_COPY: begin
        nrow = c;
        ncol = p_eff;
      end
      ST_T_B: begin
        nrow      = pi_p1;
        ncol      = rk_c;
        div_start = 1'b1;
        div_num   = sat_sub(ta, tb);
        div_den   = ndu_rd;
      end
      ST_T_M: begin
        nrow  = rk_c;
        ncol  = p_mi;
        mul_a = tq;
        mul_b = ndu_rd;
      end
      default: ;
    endcase
  end

  // Product register behind the multiplier.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Result word assembly with the falling-factorial scale.
  always_comb begin
    slot_free = !out_valid || !out_stall;
    emit_last = (oi == k_eff) && (oj == p_eff);
    scaled    = $signed({{32{ders[oi[IW-1:0]][oj[IW-1:0]][31]}},
                         ders[oi[IW-1:0]][oj[IW-1:0]]}) * $signed({56'd0, mult});
    emit_word.deriv_order = 2'(oi);
    emit_word.basis_index = span + 4'(oj) - 4'(p_eff);
    emit_word.span_index  = span;
    emit_word.value       = sat_wide(scaled);
    emit_word.divide_flag = flag;
    emit_word.last        = emit_last;
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      degree          <= DEGREE_RST;
      max_deriv_order <= DERIV_RST;
      basis_count     <= BASIS_RST;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      // Configuration writes.
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_DEGREE: degree          <= pwdata[1:0];
          REG_DERIV:  max_deriv_order <= pwdata[1:0];
          REG_BASIS:  basis_count     <= pwdata[3:0];
          default: ;
        endcase
      end

      // Outside emission the output register empties when its word is taken.
      if ((state != ST_EMIT) && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid && (in_item.action == ACT_EVAL)) begin
            x    <= in_item.point;
            flag <= 1'b0;
          end
        end
        ST_SRCH_P: begin
          if (x >= knot_rd) span <= n_eff - 4'd1;
        end
        ST_SRCH_PCHK: begin
          if (x <= knot_rd) begin
            span <= 4'(p_eff);
          end else begin
            lo   <= 4'(p_eff);
            hi   <= n_eff;
            mid  <= 4'(({1'b0, 4'(p_eff)} + {1'b0, n_eff}) >> 1);
            step <= '0;
          end
        end
        ST_MID_B: kmid <= knot_rd;
        ST_MID_C: begin
          if (hit) begin
            span <= mid;
          end else begin
            lo   <= lo2;
            hi   <= hi2;
            mid  <= mid2;
            step <= step + 3'd1;
            if (step == 3'(SEARCH_STEPS - 1)) span <= mid2;
          end
        end
        ST_BUILD_INIT: begin
          ndu[0][0] <= Q_ONE;
          j         <= CW'(1);
          c         <= '0;
          oi        <= '0;
          oj        <= '0;
          mult      <= 8'd1;
        end
        ST_LR_B: lft[j[IW-1:0]] <= sat_sub(x, knot_rd);
        ST_LR_C: begin
          rgt[j[IW-1:0]] <= sat_sub(knot_rd, x);
          r              <= '0;
          saved          <= 32'sd0;
        end
        ST_R_A: ndu[j[IW-1:0]][r[IW-1:0]] <= rsum;
        ST_R_DIV: begin
          if (div_res.done) begin
            tmp <= div_res.quot;
            if (div_res.zero) flag <= 1'b1;
          end
        end
        ST_R_M2: ndu[r[IW-1:0]][j[IW-1:0]] <= sat_add(saved, qm);
        ST_R_M3: begin
          c <= '0;
          if (r == j_m1) begin
            ndu[j[IW-1:0]][j[IW-1:0]] <= qm;
            j                         <= j + 1'b1;
          end else begin
            saved <= qm;
            r     <= r + 1'b1;
          end
        end
        ST_COPY: begin
          ders[0][c[IW-1:0]] <= ndu_rd;
          c                  <= c + 1'b1;
          r                  <= '0;
        end
        ST_DV_R: begin
          // Fresh coefficient rows for each basis function.
          for (int b = 0; b < 2; b++) begin
            for (int e = 0; e < ND; e++) begin
              acoef[b][e] <= ((b == 0) && (e == 0)) ? Q_ONE : 32'sd0;
            end
          end
          s1 <= 1'b0;
          i  <= CW'(1);
        end
        ST_DV_INIT: begin
          c    <= (i > r) ? (i - r) : '0;
          cend <= (i < (p_eff - r)) ? i : (p_eff - r);
          d    <= 32'sd0;
        end
        ST_T_A: ta <= (c == i) ? 32'sd0 : acoef[s1][c[IW-1:0]];
        ST_T_DIV: begin
          if (div_res.done) begin
            acoef[~s1][c[IW-1:0]] <= div_res.quot;
            tq                    <= div_res.quot;
            if (div_res.zero) flag <= 1'b1;
          end
        end
        ST_T_ACC: begin
          if (c == cend) begin
            ders[i[IW-1:0]][r[IW-1:0]] <= dn;
            s1                         <= ~s1;
            if (i == k_eff) r <= r + 1'b1;
            else            i <= i + 1'b1;
          end else begin
            c <= c + 1'b1;
            d <= dn;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_item  <= emit_word;
            if (oj == p_eff) begin
              oj   <= '0;
              oi   <= oi + 1'b1;
              mult <= 8'(mult * 8'(p_eff - oi));
            end else begin
              oj <= oj + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

FILE: rtl/core/bbd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependencies.
module bbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bbd_qdiv.sv
// Iterative Q16.16 divider, two quotient bits per cycle, saturating.
// Depends on bbd_pkg for the result struct and divider constants.
module bbd_qdiv (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  num,
  input  logic signed [31:0]  den,
  output bbd_pkg::div_res_t   res
);
  import bbd_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [32:0]          rem;
  logic [47:0]          dvd;
  logic [47:0]          quo;
  logic [31:0]          dmag;
  logic                 neg;
  logic [32:0]          rem_n;
  logic [47:0]          dvd_n;
  logic [47:0]          quo_n;
  logic [31:0]          num_mag;
  logic [31:0]          den_mag;
  logic signed [31:0]   qsat;

  // Magnitudes of the operands.
  assign num_mag = num[31] ? (32'd0 - num) : num;
  assign den_mag = den[31] ? (32'd0 - den) : den;

  // Restoring division steps for one cycle.
  always_comb begin
    rem_n = rem;
    dvd_n = dvd;
    quo_n = quo;
    for (int b = 0; b < DIV_PER_CYCLE; b++) begin
      rem_n = {rem_n[31:0], dvd_n[47]};
      dvd_n = {dvd_n[46:0], 1'b0};
      if (rem_n >= {1'b0, dmag}) begin
        rem_n = rem_n - {1'b0, dmag};
        quo_n = {quo_n[46:0], 1'b1};
      end else begin
        quo_n = {quo_n[46:0], 1'b0};
      end
    end
  end

  // Apply the sign and saturate to 32 bits.
  always_comb begin
    if (!neg) begin
      qsat = (quo > 48'h0000_7FFF_FFFF) ? Q_MAX : quo[31:0];
    end else begin
      qsat = (quo > 48'h0000_8000_0000) ? Q_MIN : (32'd0 - quo[31:0]);
    end
  end

  // Sequencing of one division.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        if (den == 32'sd0) begin
          res.done <= 1'b1;
          res.zero <= 1'b1;
          res.quot <= 32'sd0;
        end else begin
          busy     <= 1'b1;
          cnt      <= DIV_CNT_W'(DIV_CYCLES);
          rem      <= '0;
          dvd      <= {num_mag, 16'h0000};
          quo      <= '0;
          dmag     <= den_mag;
          neg      <= num[31] ^ den[31];
          res.zero <= 1'b0;
        end
      end else if (busy) begin
        if (cnt != '0) begin
          rem <= rem_n;
          dvd <= dvd_n;
          quo <= quo_n;
          cnt <= cnt - 1'b1;
        end else begin
          busy     <= 1'b0;
          res.done <= 1'b1;
          res.quot <= qsat;
        end
      end
    end
  end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the B-spline basis derivative block.
// It depends on bbd_pkg and bspline_basis_derivatives; a scoreboard class
// predicts every result word and plain tasks drive the word and APB ports.
`timescale 1ns / 1ps

module tb_top;
  import bbd_pkg::*;

  localparam int KNOTS    = 16;
  localparam int DEG_CAP  = 3;
  localparam int WORD_CAP = 16;
  localparam int QONE     = 65536;
  localparam int WALK     = 8;

  // Predicts the basis words for each evaluation and checks the block's output.
  class basis_scoreboard;
    int knots[KNOTS];
    int deg;
    int order;
    int nbasis;
    out_word_t pending_words[$];
    int mismatches;

    function new();
      deg = DEGREE_RST;
      order = DERIV_RST;
      nbasis = BASIS_RST;
      mismatches = 0;
      foreach (knots[i]) knots[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_DEGREE: deg = val[1:0];
        REG_DERIV:  order = val[1:0];
        REG_BASIS:  nbasis = val[3:0];
        default: ;
      endcase
    endfunction

    function int clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    function int knot_at(int idx);
      if (idx < 0) idx = 0;
      if (idx >= KNOTS) idx = KNOTS - 1;
      return knots[idx];
    endfunction

    function int fx_mul(int a, int b);
      return clip((longint'(a) * longint'(b)) / QONE);
    endfunction

    function int fx_div(int a, int b, ref bit zdiv);
      if (b == 0) begin
        zdiv = 1;
        return 0;
      end
      return clip((longint'(a) * QONE) / longint'(b));
    endfunction

    // Clamped binary search for the knot span holding x.
    function int locate_span(int n, int p, int x);
      int lo, hi, mid;
      if (x >= knot_at(n)) return n - 1;
      if (x <= knot_at(p)) return p;
      lo = p;
      hi = n;
      mid = (lo + hi) / 2;
      for (int s = 0; s < WALK; s++) begin
        if (x >= knot_at(mid) && x < knot_at(mid + 1)) break;
        if (x < knot_at(mid)) hi = mid;
        else lo = mid;
        mid = (lo + hi) / 2;
      end
      return mid;
    endfunction

    // A write word updates the store; an evaluate word queues its results.
    function void note_word(in_word_t w);
      int ndu[DEG_CAP+1][DEG_CAP+1];
      int lft[DEG_CAP+1];
      int rgt[DEG_CAP+1];
      int a[2][DEG_CAP+1];
      int ders[DEG_CAP+1][DEG_CAP+1];
      int x, saved, tmp, d, p, k, n, span, s1, s2, rk, pk, j1, j2, total, cnt;
      bit zdiv;
      longint mult;
      out_word_t o;
      if (w.action == ACT_WRITE) begin
        knots[w.knot_index] = w.knot_value;
        return;
      end
      zdiv = 0;
      x = w.point;
      p = (deg > DEG_CAP) ? DEG_CAP : deg;
      k = (order > p) ? p : order;
      n = (nbasis < p + 1) ? p + 1 : nbasis;
      span = locate_span(n, p, x);
      for (int i = 0; i <= DEG_CAP; i++) begin
        lft[i] = 0;
        rgt[i] = 0;
        for (int j = 0; j <= DEG_CAP; j++) begin
          ndu[i][j] = 0;
          ders[i][j] = 0;
        end
      end
      // Triangular table of basis values and knot differences.
      ndu[0][0] = QONE;
      for (int j = 1; j <= p; j++) begin
        lft[j] = clip(longint'(x) - knot_at(span + 1 - j));
        rgt[j] = clip(longint'(knot_at(span + j)) - x);
        saved = 0;
        for (int r = 0; r < j; r++) begin
          ndu[j][r] = clip(longint'(rgt[r+1]) + lft[j-r]);
          tmp = fx_div(ndu[r][j-1], ndu[j][r], zdiv);
          ndu[r][j] = clip(longint'(saved) + fx_mul(rgt[r+1], tmp));
          saved = fx_mul(lft[j-r], tmp);
        end
        ndu[j][j] = saved;
      end
      for (int j = 0; j <= p; j++) ders[0][j] = ndu[j][p];
      // Derivative terms, alternating between the two coefficient rows.
      for (int r = 0; r <= p; r++) begin
        s1 = 0;
        s2 = 1;
        for (int i = 0; i < 2; i++)
          for (int j = 0; j <= DEG_CAP; j++) a[i][j] = 0;
        a[0][0] = QONE;
        for (int i = 1; i <= k; i++) begin
          d = 0;
          rk = r - i;
          pk = p - i;
          if (r >= i) begin
            a[s2][0] = fx_div(a[s1][0], ndu[pk+1][rk], zdiv);
            d = fx_mul(a[s2][0], ndu[rk][pk]);
          end
          j1 = (rk >= -1) ? 1 : -rk;
          j2 = (r - 1 <= pk) ? i - 1 : p - r;
          for (int j = j1; j <= j2; j++) begin
            tmp = clip(longint'(a[s1][j]) - a[s1][j-1]);
            a[s2][j] = fx_div(tmp, ndu[pk+1][rk+j], zdiv);
            d = clip(longint'(d) + fx_mul(a[s2][j], ndu[rk+j][pk]));
          end
          if (r <= pk) begin
            tmp = clip(-longint'(a[s1][i-1]));
            a[s2][i] = fx_div(tmp, ndu[pk+1][r], zdiv);
            d = clip(longint'(d) + fx_mul(a[s2][i], ndu[r][pk]));
          end
          ders[i][r] = d;
          s1 = 1 - s1;
          s2 = 1 - s2;
        end
      end
      // Falling-factorial scaling of the derivatives.
      mult = p;
      for (int i = 1; i <= k; i++) begin
        for (int j = 0; j <= p; j++) ders[i][j] = clip(longint'(ders[i][j]) * mult);
        mult = mult * (p - i);
      end
      total = (k + 1) * (p + 1);
      if (total > WORD_CAP) total = WORD_CAP;
      cnt = 0;
      for (int i = 0; i <= k; i++) begin
        for (int j = 0; j <= p; j++) begin
          if (cnt < total) begin
            o.deriv_order = i[1:0];
            o.basis_index = 4'(span - p + j);
            o.span_index = 4'(span);
            o.value = ders[i][j];
            o.divide_flag = zdiv;
            o.last = (cnt == total - 1);
            pending_words.push_back(o);
            cnt++;
          end
        end
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_word_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  out_word_t out_item;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  bit quiet = 0;
  int ramp[KNOTS];
  basis_scoreboard sb = new();

  bspline_basis_derivatives i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watch both channels at each edge; the result side also picks its stall here.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_word(in_item);
    if (!rst && out_valid && !out_stall) sb.check_word(out_item);
    out_stall <= !quiet && ($urandom_range(99) < 18);
  end

  // Send one input word, sometimes after a random gap.
  task automatic send_word(in_word_t w);
    if (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1;
    in_item <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_knot(int idx, int val);
    in_word_t w;
    w = '0;
    w.action = ACT_WRITE;
    w.knot_index = idx[3:0];
    w.knot_value = val;
    w.point = $urandom;
    send_word(w);
  endtask

  task automatic eval_point(int x);
    in_word_t w;
    w.action = ACT_EVAL;
    w.knot_index = 4'($urandom);
    w.knot_value = $urandom;
    w.point = x;
    send_word(w);
  endtask

  // Let the block finish all pending results, then give it a quiet margin.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // APB write with setup and access phases; the scoreboard takes the value at the access edge.
  task automatic write_reg(logic [1:0] idx, int val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= PADDR_W'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic configure(int dg, int ord, int nb);
    write_reg(REG_DEGREE, dg);
    write_reg(REG_DERIV, ord);
    write_reg(REG_BASIS, nb);
  endtask

  // Load a full knot set: nondecreasing with repeats, or wholly random.
  task automatic load_knots(bit unordered);
    int v;
    v = -($urandom_range(8) * QONE);
    for (int i = 0; i < KNOTS; i++) begin
      if ($urandom_range(3) != 0) v = v + $urandom_range(2 * QONE, 1);
      ramp[i] = unordered ? int'($urandom) : v;
      write_knot(i, ramp[i]);
    end
  endtask

  // Points mostly inside the knot range, some on knots, some anywhere.
  task automatic eval_random();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) eval_point(ramp[0] + $urandom_range(ramp[KNOTS-1] - ramp[0] + 1));
    else if (pick < 8) eval_point(ramp[$urandom_range(KNOTS - 1)]);
    else eval_point($urandom);
  endtask

  initial begin
    int cfg[7][3] = '{'{3, 3, 15}, '{1, 0, 2}, '{0, 3, 0}, '{3, 0, 4},
                      '{1, 1, 15}, '{2, 3, 7}, '{3, 2, 9}};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extreme knot values, repeated knots, points at the ends.
    ramp = '{32'sh8000_0000, 0, 0, 0, QONE, 2 * QONE, 2 * QONE, 3 * QONE,
             4 * QONE, 4 * QONE, 4 * QONE, 5 * QONE, 6 * QONE, 7 * QONE,
             8 * QONE, 32'sh7FFF_FFFF};
    for (int i = 0; i < KNOTS; i++) write_knot(i, ramp[i]);
    eval_point(32'sh8000_0000);
    eval_point(32'sh7FFF_FFFF);
    eval_point(0);
    eval_point(QONE + QONE / 2);
    eval_point(2 * QONE);
    eval_point(3 * QONE + 123);
    eval_point(4 * QONE);
    eval_point(-1);
    drain();

    // Random phases over several settings, the extremes among them.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 7) configure(cfg[ph][0], cfg[ph][1], cfg[ph][2]);
      else configure($urandom_range(3), $urandom_range(3), $urandom_range(15));
      quiet = (ph == 4);
      if (ph == 0 || ph == 6 || ph == 7) load_knots(ph == 6);
      for (int e = 0; e < 5; e++) begin
        if ($urandom_range(9) == 0) write_knot($urandom_range(15), ramp[$urandom_range(15)]);
        eval_random();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("** bspline_basis_derivatives: PASSED **");
    end else begin
      $display("** bspline_basis_derivatives: FAILED **");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("** bspline_basis_derivatives: FAILED **");
    $finish;
  end

endmodule
